/* rtl/core/cpd_pkg.sv */
package cpd_pkg;
	localparam int NUM_SYMBOLS_DEF = 256;
	localparam int MAX_CODE_LEN_DEF = 32;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_BIT   = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_SYMBOL  = 2'd0,
		ST_NOMATCH = 2'd1,
		ST_BADLEN  = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] code_length;
		logic       bit_value;
	} in_word_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] decoded_symbol;
	} out_word_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_COUNT,
		S_OFFS,
		S_PLACE,
		S_LOOK,
		S_SYM
	} state_t;
endpackage

/* rtl/core/canonical_prefix_decoder_top.sv */
// Canonical prefix code decoder. Send NUM_SYMBOLS load words (op 0), one code length per
// symbol in symbol order; after the last one the block builds its tables by a counting
// pass over the symbol length memory, a walk over the per-length table, and a second
// pass over the symbol length memory that writes the sorted symbol memory. Then each bit
// word (op 1) does one per-length table read, and a matched bit then reads the sorted
// symbol memory. Results go through a two-word output queue, so the next input word is
// taken while one result waits; input stalls while the table build or a lookup runs and
// while the queue is full.
module canonical_prefix_decoder_top import cpd_pkg::*; #(
	parameter int NUM_SYMBOLS = NUM_SYMBOLS_DEF,
	parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_word_t  in_word,
	output logic      out_valid,
	input  logic      out_stall,
	output out_word_t out_word
);
	localparam int SW = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
	localparam int CW = $clog2(NUM_SYMBOLS + 1);
	localparam int LW = $clog2(MAX_CODE_LEN + 1);
	localparam int IW = $clog2(MAX_CODE_LEN);
	localparam int AW = MAX_CODE_LEN;
	localparam int FW = AW + CW + 1;

	// per-length tables hold lengths 1 to MAX_CODE_LEN at index length - 1
	logic [7:0] len_mem [NUM_SYMBOLS];
	logic [7:0] sort_mem [NUM_SYMBOLS];
	logic [CW-1:0] cnt_q [MAX_CODE_LEN];
	logic [CW-1:0] fill_q [MAX_CODE_LEN];
	logic [CW-1:0] offs_q [MAX_CODE_LEN];
	logic [FW-1:0] first_q [MAX_CODE_LEN];

	state_t state_q, state_d;
	logic [CW-1:0] load_idx_q;
	logic [CW-1:0] sidx_q;
	logic [LW-1:0] lidx_q;
	logic          rd_v_q;
	logic [SW-1:0] rd_sym_q;
	logic [7:0]    len_rd_q;
	logic          ready_q;
	logic [AW-1:0] acc_q;
	logic [LW-1:0] bits_q;
	logic [CW-1:0] running_q;
	logic [FW-1:0] prev_code_q;
	logic          seen_q;
	logic [7:0]    sym_rd_q;
	logic          hold_v_q;
	out_word_t     hold_q;
	logic          hold2_v_q;
	out_word_t     hold2_q;

	logic accept;
	logic pop;
	assign in_stall = (state_q != S_IDLE) || hold2_v_q;
	assign accept = in_valid && !in_stall;
	assign out_valid = hold_v_q;
	assign out_word = hold_q;
	assign pop = hold_v_q && !out_stall;

	logic [IW-1:0] li_n;
	logic [IW-1:0] bi_n;
	logic [IW-1:0] ri_n;
	assign li_n = IW'(lidx_q - LW'(1));
	assign bi_n = IW'(bits_q - LW'(1));
	assign ri_n = IW'(len_rd_q[LW-1:0] - LW'(1));

	logic [AW-1:0] acc_n;
	logic [LW-1:0] bits_n;
	logic [FW-1:0] acc_ext;
	logic [FW-1:0] diff;
	logic          hit;
	logic          pass_done;
	logic [SW-1:0] pos_n;
	assign acc_n = {acc_q[AW-2:0], in_word.bit_value};
	assign bits_n = bits_q + LW'(1);
	assign acc_ext = {{(FW-AW){1'b0}}, acc_q};
	assign diff = acc_ext - first_q[bi_n];
	assign hit = (cnt_q[bi_n] != '0) && (acc_ext >= first_q[bi_n]) &&
		(diff < {{(FW-CW){1'b0}}, cnt_q[bi_n]});
	assign pos_n = SW'(offs_q[bi_n] + diff[CW-1:0]);
	assign pass_done = (sidx_q == CW'(NUM_SYMBOLS));

	logic len_ok;
	assign len_ok = (len_rd_q >= 8'd1) && ({24'd0, len_rd_q} <= 32'(MAX_CODE_LEN));

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && in_word.op == OP_LOAD &&
					{24'd0, in_word.code_length} <= 32'(MAX_CODE_LEN) &&
					(ready_q ? (NUM_SYMBOLS == 1) : (load_idx_q == CW'(NUM_SYMBOLS - 1))))
					state_d = S_COUNT;
				else if (accept && in_word.op == OP_BIT && ready_q)
					state_d = S_LOOK;
			end
			S_COUNT: if (pass_done && !rd_v_q) state_d = S_OFFS;
			S_OFFS:  if (lidx_q == LW'(MAX_CODE_LEN)) state_d = S_PLACE;
			S_PLACE: if (pass_done && !rd_v_q) state_d = S_IDLE;
			S_LOOK:  if (hit) state_d = S_SYM; else state_d = S_IDLE;
			S_SYM:   state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	logic      res_v;
	out_word_t res_w;
	always_comb begin
		res_v = 1'b0;
		res_w = '0;
		case (state_q)
			S_IDLE: begin
				if (accept && in_word.op == OP_LOAD &&
					{24'd0, in_word.code_length} > 32'(MAX_CODE_LEN)) begin
					res_v = 1'b1;
					res_w = '{status: ST_BADLEN, decoded_symbol: 8'd0};
				end else if (accept && in_word.op == OP_BIT && !ready_q) begin
					res_v = 1'b1;
					res_w = '{status: ST_BADLEN, decoded_symbol: 8'd0};
				end
			end
			S_LOOK: begin
				if (!hit && bits_q == LW'(MAX_CODE_LEN)) begin
					res_v = 1'b1;
					res_w = '{status: ST_NOMATCH, decoded_symbol: 8'd0};
				end
			end
			S_SYM: begin
				res_v = 1'b1;
				res_w = '{status: ST_SYMBOL, decoded_symbol: sym_rd_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept && in_word.op == OP_LOAD &&
			{24'd0, in_word.code_length} <= 32'(MAX_CODE_LEN))
			len_mem[ready_q ? SW'(0) : load_idx_q[SW-1:0]] <= in_word.code_length;
		len_rd_q <= len_mem[sidx_q[SW-1:0]];
		sym_rd_q <= sort_mem[pos_n];
		if (state_q == S_PLACE && rd_v_q && len_ok &&
			fill_q[ri_n] < CW'(NUM_SYMBOLS))
			sort_mem[fill_q[ri_n][SW-1:0]] <= 8'(rd_sym_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			load_idx_q <= '0;
			ready_q <= 1'b0;
			acc_q <= '0;
			bits_q <= '0;
			sidx_q <= '0;
			lidx_q <= '0;
			rd_v_q <= 1'b0;
			rd_sym_q <= '0;
			running_q <= '0;
			prev_code_q <= '0;
			seen_q <= 1'b0;
			hold_v_q <= 1'b0;
			hold_q <= '0;
			hold2_v_q <= 1'b0;
			hold2_q <= '0;
			for (int i = 0; i < MAX_CODE_LEN; i++) begin
				cnt_q[i] <= '0;
				fill_q[i] <= '0;
				offs_q[i] <= '0;
				first_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (!hold_v_q || pop) begin
				if (hold2_v_q) begin
					hold_v_q <= 1'b1;
					hold_q <= hold2_q;
					hold2_v_q <= res_v;
					if (res_v) hold2_q <= res_w;
				end else begin
					hold_v_q <= res_v;
					if (res_v) hold_q <= res_w;
				end
			end else if (res_v) begin
				hold2_v_q <= 1'b1;
				hold2_q <= res_w;
			end
			rd_v_q <= (state_q == S_COUNT || state_q == S_PLACE) && !pass_done;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (in_word.op)
							OP_LOAD: begin
								acc_q <= '0;
								bits_q <= '0;
								if ({24'd0, in_word.code_length} > 32'(MAX_CODE_LEN)) begin
									if (ready_q) begin
										ready_q <= 1'b0;
										load_idx_q <= '0;
									end
								end else begin
									ready_q <= 1'b0;
									load_idx_q <= ready_q ? CW'(1) : load_idx_q + CW'(1);
									if (state_d == S_COUNT) begin
										sidx_q <= '0;
										for (int i = 0; i < MAX_CODE_LEN; i++) cnt_q[i] <= '0;
									end
								end
							end
							OP_CLEAR: begin
								acc_q <= '0;
								bits_q <= '0;
							end
							OP_BIT: begin
								if (!ready_q) begin
									acc_q <= '0;
									bits_q <= '0;
								end else begin
									acc_q <= acc_n;
									bits_q <= bits_n;
								end
							end
							default: ;
						endcase
					end
				end
				S_COUNT: begin
					if (!pass_done)
						sidx_q <= sidx_q + CW'(1);
					if (rd_v_q && len_ok)
						cnt_q[ri_n] <= cnt_q[ri_n] + CW'(1);
					if (pass_done && !rd_v_q) begin
						lidx_q <= LW'(1);
						running_q <= '0;
						seen_q <= 1'b0;
						prev_code_q <= '0;
					end
				end
				S_OFFS: begin
					offs_q[li_n] <= running_q;
					fill_q[li_n] <= running_q;
					running_q <= running_q + cnt_q[li_n];
					if (cnt_q[li_n] == '0) first_q[li_n] <= '0;
					else begin
						first_q[li_n] <= seen_q ? (prev_code_q << 1) : '0;
						prev_code_q <= (seen_q ? (prev_code_q << 1) : '0) +
							FW'(cnt_q[li_n]);
						seen_q <= 1'b1;
					end
					if (cnt_q[li_n] == '0 && seen_q) prev_code_q <= prev_code_q << 1;
					lidx_q <= lidx_q + LW'(1);
					if (lidx_q == LW'(MAX_CODE_LEN)) sidx_q <= '0;
				end
				S_PLACE: begin
					if (!pass_done) begin
						sidx_q <= sidx_q + CW'(1);
						rd_sym_q <= sidx_q[SW-1:0];
					end
					if (rd_v_q && len_ok && fill_q[ri_n] < CW'(NUM_SYMBOLS))
						fill_q[ri_n] <= fill_q[ri_n] + CW'(1);
					if (pass_done && !rd_v_q) ready_q <= 1'b1;
				end
				S_LOOK: begin
					if (hit || bits_q == LW'(MAX_CODE_LEN)) begin
						acc_q <= '0;
						bits_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> in_stall)
		else $error("input taken while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(hold_v_q && out_stall) |=> (hold_v_q && $stable(hold_q)))
		else $error("result lost under stall");
	assert property (@(posedge clk) disable iff (!arst_n)
		(bits_q <= LW'(MAX_CODE_LEN)))
		else $error("bit count overrun");
endmodule

/* test/cpd_checker.sv */
module cpd_checker import cpd_pkg::*; #(
	parameter int NSYM = 256,
	parameter int MAXL = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_stall,
	input  in_word_t  in_word,
	input  logic      out_valid,
	input  logic      out_stall,
	input  out_word_t out_word,
	output int        fail_count,
	output int        pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [7:0]  len_mem [NSYM];
	logic [7:0]  sym_order [NSYM];
	int unsigned len_count [MAXL+1];
	logic [63:0] first_code [MAXL+1];
	int unsigned len_offset [MAXL+1];
	int unsigned load_pos;
	logic [63:0] acc;
	int unsigned nbits;
	bit          ready;
	out_word_t   expected_q[$];

	function automatic out_word_t mk(status_t st, logic [7:0] sym);
		out_word_t w;
		w.status = st;
		w.decoded_symbol = sym;
		return w;
	endfunction

	task automatic build_codes();
		int unsigned fill [MAXL+1];
		int unsigned run;
		int prev;
		run = 0;
		prev = -1;
		for (int l = 0; l <= MAXL; l++) begin
			len_count[l] = 0;
		end
		for (int s = 0; s < NSYM; s++) begin
			if (len_mem[s] >= 1 && len_mem[s] <= MAXL)
				len_count[len_mem[s]]++;
		end
		len_offset[0] = 0;
		first_code[0] = 0;
		for (int l = 1; l <= MAXL; l++) begin
			len_offset[l] = run;
			fill[l] = run;
			run = (run + len_count[l]) & 16'hffff;
		end
		for (int s = 0; s < NSYM; s++) begin
			if (len_mem[s] >= 1 && len_mem[s] <= MAXL && fill[len_mem[s]] < NSYM) begin
				sym_order[fill[len_mem[s]]] = 8'(s);
				fill[len_mem[s]]++;
			end
		end
		for (int l = 1; l <= MAXL; l++) begin
			if (len_count[l] == 0) begin
				first_code[l] = 0;
			end else begin
				if (prev < 0)
					first_code[l] = 0;
				else
					first_code[l] = (first_code[prev] + 64'(len_count[prev])) << (l - prev);
				prev = l;
			end
		end
	endtask

	task automatic predict_word(in_word_t w);
		logic [63:0] pos;
		case (op_t'(w.op))
			OP_LOAD: begin
				if (ready) begin
					ready = 0;
					load_pos = 0;
				end
				acc = 0;
				nbits = 0;
				if (w.code_length > MAXL) begin
					expected_q.push_back(mk(ST_BADLEN, 8'd0));
				end else begin
					if (load_pos < NSYM) begin
						len_mem[load_pos] = w.code_length;
						load_pos++;
					end
					if (load_pos >= NSYM) begin
						build_codes();
						ready = 1;
					end
				end
			end
			OP_CLEAR: begin
				acc = 0;
				nbits = 0;
			end
			OP_BIT: begin
				if (!ready) begin
					acc = 0;
					nbits = 0;
					expected_q.push_back(mk(ST_BADLEN, 8'd0));
				end else begin
					acc = (acc << 1) | 64'(w.bit_value);
					nbits++;
					if (nbits <= MAXL && len_count[nbits] != 0 && acc >= first_code[nbits]
							&& acc - first_code[nbits] < len_count[nbits]) begin
						pos = 64'(len_offset[nbits]) + (acc - first_code[nbits]);
						expected_q.push_back(mk(ST_SYMBOL, pos < NSYM ? sym_order[pos] : 8'd0));
						acc = 0;
						nbits = 0;
					end else if (nbits >= MAXL) begin
						acc = 0;
						nbits = 0;
						expected_q.push_back(mk(ST_NOMATCH, 8'd0));
					end
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_word_t e;
		if (!arst_n) begin
			fail_count <= 0;
			pending <= 0;
			load_pos = 0;
			acc = 0;
			nbits = 0;
			ready = 0;
			for (int l = 0; l <= MAXL; l++) begin
				len_count[l] = 0;
				first_code[l] = 0;
				len_offset[l] = 0;
			end
			expected_q.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					$error("unexpected word status=%0d symbol=%0d", out_word.status,
						out_word.decoded_symbol);
					fail_count <= fail_count + 1;
				end else begin
					e = expected_q.pop_front();
					if (out_word.status !== e.status) begin
						$error("status expected %0d actual %0d", e.status, out_word.status);
						fail_count <= fail_count + 1;
					end else if (out_word.decoded_symbol !== e.decoded_symbol) begin
						$error("decoded_symbol expected %0d actual %0d", e.decoded_symbol,
							out_word.decoded_symbol);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (in_valid && !in_stall)
				predict_word(in_word);
			pending <= expected_q.size();
		end
	end
endmodule

/* test/canonical_prefix_decoder_top_tb.sv */
module canonical_prefix_decoder_top_tb import cpd_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NSYM = NUM_SYMBOLS_DEF;
	localparam int MAXL = MAX_CODE_LEN_DEF;
	localparam int IDLE_LIMIT = 20000;

	logic      clk = 0;
	logic      arst_n = 0;
	logic      in_valid = 0;
	logic      in_stall;
	in_word_t  in_word = '0;
	logic      out_valid;
	logic      out_stall = 0;
	out_word_t out_word;
	int        fail_count;
	int        pending;
	int        idle_cycles = 0;
	int        burst_left = 0;
	logic [7:0] lens [NSYM];

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	canonical_prefix_decoder_top dut (.*);

	cpd_checker #(.NSYM(NSYM), .MAXL(MAXL)) chk (.*);

	// receiver stall pattern: long open stretches, then heavy stalling
	always @(negedge clk) begin
		int ph;
		ph = int'(($time / 20) % 3000);
		if (ph < 800)
			out_stall <= 0;
		else if (ph < 2000)
			out_stall <= ($urandom_range(0, 3) == 0);
		else
			out_stall <= ($urandom_range(0, 1) == 0);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic send(op_t op, logic [7:0] len, logic b);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				in_valid <= 0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		in_word <= '{op: op, code_length: len, bit_value: b};
		in_valid <= 1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_header(int kind);
		for (int s = 0; s < NSYM; s++) begin
			case (kind)
				0: lens[s] = 8;
				1: lens[s] = (s < 2) ? 8'd1 : 8'd0;
				2: lens[s] = 0;
				3: lens[s] = (s == 255) ? 8'd32 : ((s < 31) ? 8'(s + 1) : 8'd0);
				4: lens[s] = $urandom_range(0, 3) == 0 ? 8'd0 : 8'($urandom_range(1, 10));
				default: lens[s] = 8'($urandom_range(0, 4));
			endcase
			send(OP_LOAD, lens[s], $urandom_range(0, 1));
		end
	endtask

	task automatic send_symbol_bits(int n);
		int s;
		for (int k = 0; k < n; k++) begin
			s = $urandom_range(0, 9);
			if (s == 0)
				send(OP_CLEAR, 8'($urandom), $urandom_range(0, 1));
			else if (s == 1)
				send(OP_NONE, 8'($urandom), $urandom_range(0, 1));
			else
				send(OP_BIT, 8'($urandom), $urandom_range(0, 1));
		end
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		// directed: not ready, bad lengths, clear, unused op
		send(OP_BIT, 8'h00, 1);
		send(OP_LOAD, 8'hff, 0);
		send(OP_LOAD, 8'd33, 1);
		send(OP_CLEAR, 8'h55, 0);
		send(OP_NONE, 8'haa, 1);
		send(OP_BIT, 8'hff, 0);
		// one random header with a random bit stream
		send_header(4);
		send_symbol_bits(120);
		// bad length drops the table, then bits are refused
		send(OP_LOAD, 8'($urandom_range(33, 255)), 0);
		for (int k = 0; k < 8; k++)
			send(OP_BIT, 8'($urandom), $urandom_range(0, 1));
		in_valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
